>>> sv/assert_macros.svh
// Assertion macros for the RTL of the flood-fill block; gfr_engine is the module that uses them.
// Needs nothing else; files that assert take it in by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define GFR_ASSERT_NOW(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define GFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/gfr_pkg.sv
// Package of the grid flood-fill block: payload types, codes and helpers.
// Used by every module of the block; depends on nothing.
`default_nettype none

package gfr_pkg;

    localparam int CFG_W          = 7;
    localparam int CNT_SAT_W      = 13;
    localparam int APB_AW         = 3;
    localparam int APB_DW         = 32;
    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    localparam logic [CFG_W-1:0]     DIM_RESET = 7'd64;
    localparam logic [CNT_SAT_W-1:0] COUNT_MAX = 13'h1FFF;

    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    localparam logic [2:0] KIND_FLOOR = 3'd0;
    localparam logic [2:0] KIND_WALL  = 3'd1;
    localparam logic [2:0] KIND_EXIT  = 3'd2;
    localparam logic [2:0] KIND_COLL  = 3'd3;
    localparam logic [2:0] KIND_START = 3'd4;

    localparam logic [2:0] FAIL_OK           = 3'd0;
    localparam logic [2:0] FAIL_NO_EXIT      = 3'd1;
    localparam logic [2:0] FAIL_NO_COLL      = 3'd2;
    localparam logic [2:0] FAIL_NO_START     = 3'd3;
    localparam logic [2:0] FAIL_EXIT_UNREACH = 3'd4;
    localparam logic [2:0] FAIL_COLL_UNREACH = 3'd5;
    localparam logic [2:0] FAIL_MANY_STARTS  = 3'd6;
    localparam logic [2:0] FAIL_MANY_EXITS   = 3'd7;

    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    typedef struct packed {
        logic [2:0] cell_kind;
        logic       last_cell;
    } t_in_item;

    typedef struct packed {
        logic                 map_valid;
        logic                 exit_reachable;
        logic [CNT_SAT_W-1:0] reachable_collectibles;
        logic [CNT_SAT_W-1:0] total_collectibles;
        logic [2:0]           fail_code;
    } t_out_item;

    typedef struct packed {
        logic             settle;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] w_m1;
    } t_dims;

    typedef struct packed {
        logic                 done;
        logic                 exit_seen;
        logic [CNT_SAT_W-1:0] exit_count;
        logic [CNT_SAT_W-1:0] start_count;
        logic [CNT_SAT_W-1:0] coll_count;
        logic [CNT_SAT_W-1:0] reached;
    } t_tally;

    function automatic logic [CNT_SAT_W-1:0] sat_inc(input logic [CNT_SAT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + 13'd1;
    endfunction

endpackage

`default_nettype wire

>>> sv/gfr_alu.sv
// Shared add and subtract unit of the flood-fill sequencer.
// Depends on gfr_pkg for the operation codes.
`default_nettype none

module gfr_alu #(
    parameter int W = 14
) (
    input  wire logic         i_op,
    input  wire logic [W-1:0] i_a,
    input  wire logic [W-1:0] i_b,
    output logic      [W-1:0] o_y,
    output logic              o_carry
);

    logic [W:0] sum;

    always_comb begin
        if (i_op == gfr_pkg::ALU_SUB) begin
            sum = {1'b0, i_a} + {1'b0, ~i_b} + {{W{1'b0}}, 1'b1};
        end else begin
            sum = {1'b0, i_a} + {1'b0, i_b};
        end
    end

    assign o_y     = sum[W-1:0];
    assign o_carry = sum[W];

endmodule

`default_nettype wire

>>> sv/gfr_cfg.sv
// Configuration registers on the APB-style port, and the map shape derived from them.
// Depends on gfr_pkg for register codes and the shape struct.
`default_nettype none

module gfr_cfg #(
    parameter int MAX_WIDTH  = gfr_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gfr_pkg::DEF_MAX_HEIGHT,
    parameter int CNT_W      = 13
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [gfr_pkg::APB_AW-1:0]  paddr,
    input  wire logic [gfr_pkg::APB_DW-1:0]  pwdata,
    output logic      [gfr_pkg::APB_DW-1:0]  prdata,
    output logic                             pready,
    output gfr_pkg::t_dims                   o_dims,
    output logic      [CNT_W-1:0]            o_cap
);

    localparam int CW = gfr_pkg::CFG_W;

    logic [CW-1:0]   r_grid_width;
    logic [CW-1:0]   r_grid_height;
    logic            r_settle;
    logic [CW-1:0]   r_w;
    logic [CW-1:0]   r_w_m1;
    logic [CNT_W-1:0] r_cap;
    logic [CW-1:0]   n_w;
    logic [CW-1:0]   n_h;
    logic [2*CW-1:0] prod;
    logic            wr_en;

    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= gfr_pkg::DIM_RESET;
            r_grid_height <= gfr_pkg::DIM_RESET;
            r_settle      <= 1'b1;
        end else begin
            r_settle <= wr_en;
            if (wr_en) begin
                unique case (paddr[2])
                    gfr_pkg::REG_GRID_WIDTH:  r_grid_width  <= pwdata[CW-1:0];
                    gfr_pkg::REG_GRID_HEIGHT: r_grid_height <= pwdata[CW-1:0];
                endcase
            end
        end
    end

    always_comb begin
        if (r_grid_width == '0) begin
            n_w = {{(CW-1){1'b0}}, 1'b1};
        end else if (int'(r_grid_width) > MAX_WIDTH) begin
            n_w = CW'(MAX_WIDTH);
        end else begin
            n_w = r_grid_width;
        end
        if (r_grid_height == '0) begin
            n_h = {{(CW-1){1'b0}}, 1'b1};
        end else if (int'(r_grid_height) > MAX_HEIGHT) begin
            n_h = CW'(MAX_HEIGHT);
        end else begin
            n_h = r_grid_height;
        end
        prod = {{CW{1'b0}}, n_w} * {{CW{1'b0}}, n_h};
    end

    always_ff @(posedge i_clk) begin
        r_w    <= n_w;
        r_w_m1 <= n_w - {{(CW-1){1'b0}}, 1'b1};
        r_cap  <= CNT_W'(prod);
    end

    always_comb begin
        unique case (paddr[2])
            gfr_pkg::REG_GRID_WIDTH:  prdata = {{(gfr_pkg::APB_DW-CW){1'b0}}, r_grid_width};
            gfr_pkg::REG_GRID_HEIGHT: prdata = {{(gfr_pkg::APB_DW-CW){1'b0}}, r_grid_height};
        endcase
    end

    assign pready      = 1'b1;
    assign o_dims.settle = r_settle;
    assign o_dims.w      = r_w;
    assign o_dims.w_m1   = r_w_m1;
    assign o_cap         = r_cap;

endmodule

`default_nettype wire

>>> sv/gfr_engine.sv
// Cell loading, cell and stack memories and the flood-fill sequencer.
// Depends on gfr_pkg, gfr_alu and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module gfr_engine #(
    parameter int MAX_WIDTH  = gfr_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gfr_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire gfr_pkg::t_dims    i_dims,
    input  wire logic [$clog2(MAX_WIDTH*MAX_HEIGHT+1)-1:0] i_cap,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire gfr_pkg::t_in_item i_in_data,
    input  wire logic              i_res_room,
    output gfr_pkg::t_tally        o_tally
);

    localparam int CAP   = MAX_WIDTH * MAX_HEIGHT;
    localparam int IDX_W = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int CNT_W = $clog2(CAP + 1);
    localparam int ALU_W = CNT_W + 1;
    localparam int XW    = gfr_pkg::CFG_W;
    localparam int SW    = (IDX_W > 1) ? $clog2(IDX_W) : 1;
    localparam int SAT_W = gfr_pkg::CNT_SAT_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAP);

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_MOD   = 4'd1;
    localparam logic [3:0] S_CAND  = 4'd2;
    localparam logic [3:0] S_PROBE = 4'd3;
    localparam logic [3:0] S_CHECK = 4'd4;
    localparam logic [3:0] S_POP   = 4'd5;
    localparam logic [3:0] S_POPW  = 4'd6;
    localparam logic [3:0] S_DONE  = 4'd7;

    localparam logic [1:0] NBR_LEFT  = 2'd0;
    localparam logic [1:0] NBR_RIGHT = 2'd1;
    localparam logic [1:0] NBR_UP    = 2'd2;
    localparam logic [1:0] NBR_DOWN  = 2'd3;

    logic [3:0]       r_state,     n_state;
    logic [CNT_W-1:0] r_load_pos,  n_load_pos;
    logic [IDX_W-1:0] r_start_pos, n_start_pos;
    logic [SAT_W-1:0] r_exit_cnt,  n_exit_cnt;
    logic [SAT_W-1:0] r_start_cnt, n_start_cnt;
    logic [SAT_W-1:0] r_coll_cnt,  n_coll_cnt;
    logic [SAT_W-1:0] r_reached,   n_reached;
    logic             r_exit_seen, n_exit_seen;
    logic [CNT_W-1:0] r_sp,        n_sp;
    logic [1:0]       r_nbr,       n_nbr;
    logic             r_from_start, n_from_start;
    logic [IDX_W-1:0] r_cur_idx,   n_cur_idx;
    logic [XW-1:0]    r_cur_x,     n_cur_x;
    logic [ALU_W-1:0] r_cand,      n_cand;
    logic [XW-1:0]    r_cand_x,    n_cand_x;
    logic [ALU_W-1:0] r_rem,       n_rem;
    logic [SW-1:0]    r_step,      n_step;

    logic [3:0]           r_cell_mem [CAP];
    logic [3:0]           r_cell_rd;
    logic [IDX_W+XW-1:0]  r_stack_mem [CAP];
    logic [IDX_W+XW-1:0]  r_stack_rd;

    logic             cell_we;
    logic [IDX_W-1:0] cell_waddr;
    logic [3:0]       cell_wdata;
    logic             stk_we;
    logic [CNT_W-1:0] sp_m1;

    logic             alu_op;
    logic [ALU_W-1:0] alu_a;
    logic [ALU_W-1:0] alu_b;
    logic [ALU_W-1:0] alu_y;
    logic             alu_carry;
    logic [ALU_W-1:0] rem_sh;
    logic             cand_ok;
    logic [XW-1:0]    cand_x;
    logic             in_acc;
    logic             nbr_last;
    logic             open_cell;

    gfr_alu #(.W(ALU_W)) u_alu (
        .i_op    (alu_op),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_y     (alu_y),
        .o_carry (alu_carry)
    );

    assign o_in_ready = (r_state == S_LOAD) && !i_dims.settle;
    assign in_acc     = i_in_valid && o_in_ready;
    assign rem_sh     = {r_rem[ALU_W-2:0], r_start_pos[r_step]};
    assign nbr_last   = r_from_start || (r_nbr == NBR_DOWN);
    assign open_cell  = (r_cell_rd[2:0] != gfr_pkg::KIND_WALL) && !r_cell_rd[3];
    assign sp_m1      = r_sp - {{(CNT_W-1){1'b0}}, 1'b1};

    always_comb begin
        alu_op  = gfr_pkg::ALU_SUB;
        alu_a   = ALU_W'(r_load_pos);
        alu_b   = ALU_W'(i_cap);
        cand_ok = 1'b0;
        cand_x  = r_cur_x;
        unique case (r_state)
            S_MOD: begin
                alu_a = rem_sh;
                alu_b = ALU_W'(i_dims.w);
            end
            S_CAND: begin
                alu_a = ALU_W'(r_cur_idx);
                unique case (r_nbr)
                    NBR_LEFT: begin
                        alu_b   = ALU_W'(1);
                        cand_ok = (r_cur_x != '0);
                        cand_x  = r_cur_x - {{(XW-1){1'b0}}, 1'b1};
                    end
                    NBR_RIGHT: begin
                        alu_op  = gfr_pkg::ALU_ADD;
                        alu_b   = ALU_W'(1);
                        cand_ok = (r_cur_x != i_dims.w_m1);
                        cand_x  = r_cur_x + {{(XW-1){1'b0}}, 1'b1};
                    end
                    NBR_UP: begin
                        alu_b   = ALU_W'(i_dims.w);
                        cand_ok = alu_carry;
                    end
                    NBR_DOWN: begin
                        alu_op  = gfr_pkg::ALU_ADD;
                        alu_b   = ALU_W'(i_dims.w);
                        cand_ok = 1'b1;
                    end
                endcase
            end
            S_PROBE: begin
                alu_a = r_cand;
                alu_b = ALU_W'(r_load_pos);
            end
            default: begin
                alu_op = gfr_pkg::ALU_SUB;
            end
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_load_pos   = r_load_pos;
        n_start_pos  = r_start_pos;
        n_exit_cnt   = r_exit_cnt;
        n_start_cnt  = r_start_cnt;
        n_coll_cnt   = r_coll_cnt;
        n_reached    = r_reached;
        n_exit_seen  = r_exit_seen;
        n_sp         = r_sp;
        n_nbr        = r_nbr;
        n_from_start = r_from_start;
        n_cur_idx    = r_cur_idx;
        n_cur_x      = r_cur_x;
        n_cand       = r_cand;
        n_cand_x     = r_cand_x;
        n_rem        = r_rem;
        n_step       = r_step;
        cell_we      = 1'b0;
        cell_waddr   = r_cand[IDX_W-1:0];
        cell_wdata   = {1'b1, r_cell_rd[2:0]};
        stk_we       = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    if (!alu_carry) begin
                        cell_we    = 1'b1;
                        cell_waddr = r_load_pos[IDX_W-1:0];
                        cell_wdata = {1'b0, i_in_data.cell_kind};
                        n_load_pos = r_load_pos + {{(CNT_W-1){1'b0}}, 1'b1};
                        case (i_in_data.cell_kind)
                            gfr_pkg::KIND_EXIT: n_exit_cnt = gfr_pkg::sat_inc(r_exit_cnt);
                            gfr_pkg::KIND_COLL: n_coll_cnt = gfr_pkg::sat_inc(r_coll_cnt);
                            gfr_pkg::KIND_START: begin
                                n_start_cnt = gfr_pkg::sat_inc(r_start_cnt);
                                n_start_pos = r_load_pos[IDX_W-1:0];
                            end
                            default: begin
                                n_exit_cnt = r_exit_cnt;
                            end
                        endcase
                    end
                    if (i_in_data.last_cell) begin
                        n_state = S_MOD;
                        n_rem   = '0;
                        n_step  = SW'(IDX_W - 1);
                    end
                end
            end
            S_MOD: begin
                if (r_start_cnt == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_rem = alu_carry ? alu_y : rem_sh;
                    if (r_step == '0) begin
                        n_cand       = ALU_W'(r_start_pos);
                        n_cand_x     = XW'(n_rem);
                        n_from_start = 1'b1;
                        n_state      = S_PROBE;
                    end else begin
                        n_step = r_step - {{(SW-1){1'b0}}, 1'b1};
                    end
                end
            end
            S_CAND: begin
                if (cand_ok) begin
                    n_cand   = alu_y;
                    n_cand_x = cand_x;
                    n_state  = S_PROBE;
                end else if (nbr_last) begin
                    n_from_start = 1'b0;
                    n_state      = S_POP;
                end else begin
                    n_nbr   = r_nbr + 2'd1;
                    n_state = S_CAND;
                end
            end
            S_PROBE: begin
                if (!alu_carry) begin
                    n_state = S_CHECK;
                end else if (nbr_last) begin
                    n_from_start = 1'b0;
                    n_state      = S_POP;
                end else begin
                    n_nbr   = r_nbr + 2'd1;
                    n_state = S_CAND;
                end
            end
            S_CHECK: begin
                if (open_cell) begin
                    cell_we = 1'b1;
                    if (r_cell_rd[2:0] == gfr_pkg::KIND_EXIT) begin
                        n_exit_seen = 1'b1;
                    end
                    if (r_cell_rd[2:0] == gfr_pkg::KIND_COLL) begin
                        n_reached = gfr_pkg::sat_inc(r_reached);
                    end
                    if (r_sp < CAP_CNT) begin
                        stk_we = 1'b1;
                        n_sp   = r_sp + {{(CNT_W-1){1'b0}}, 1'b1};
                    end
                end
                if (nbr_last) begin
                    n_from_start = 1'b0;
                    n_state      = S_POP;
                end else begin
                    n_nbr   = r_nbr + 2'd1;
                    n_state = S_CAND;
                end
            end
            S_POP: begin
                if (r_sp == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_sp    = sp_m1;
                    n_state = S_POPW;
                end
            end
            S_POPW: begin
                n_cur_idx = r_stack_rd[IDX_W+XW-1:XW];
                n_cur_x   = r_stack_rd[XW-1:0];
                n_nbr     = NBR_LEFT;
                n_state   = S_CAND;
            end
            S_DONE: begin
                if (i_res_room) begin
                    n_load_pos  = '0;
                    n_start_pos = '0;
                    n_exit_cnt  = '0;
                    n_start_cnt = '0;
                    n_coll_cnt  = '0;
                    n_reached   = '0;
                    n_exit_seen = 1'b0;
                    n_sp        = '0;
                    n_state     = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_load_pos   <= '0;
            r_start_pos  <= '0;
            r_exit_cnt   <= '0;
            r_start_cnt  <= '0;
            r_coll_cnt   <= '0;
            r_reached    <= '0;
            r_exit_seen  <= 1'b0;
            r_sp         <= '0;
            r_nbr        <= NBR_LEFT;
            r_from_start <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_load_pos   <= n_load_pos;
            r_start_pos  <= n_start_pos;
            r_exit_cnt   <= n_exit_cnt;
            r_start_cnt  <= n_start_cnt;
            r_coll_cnt   <= n_coll_cnt;
            r_reached    <= n_reached;
            r_exit_seen  <= n_exit_seen;
            r_sp         <= n_sp;
            r_nbr        <= n_nbr;
            r_from_start <= n_from_start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_idx <= n_cur_idx;
        r_cur_x   <= n_cur_x;
        r_cand    <= n_cand;
        r_cand_x  <= n_cand_x;
        r_rem     <= n_rem;
        r_step    <= n_step;
    end

    // The top bit of a cell entry is its visited mark; loading writes it clear.
    always_ff @(posedge i_clk) begin
        if (cell_we) begin
            r_cell_mem[cell_waddr] <= cell_wdata;
        end
        r_cell_rd <= r_cell_mem[r_cand[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stack_mem[r_sp[IDX_W-1:0]] <= {r_cand[IDX_W-1:0], r_cand_x};
        end
        r_stack_rd <= r_stack_mem[sp_m1[IDX_W-1:0]];
    end

    assign o_tally.done        = (r_state == S_DONE) && i_res_room;
    assign o_tally.exit_seen   = r_exit_seen;
    assign o_tally.exit_count  = r_exit_cnt;
    assign o_tally.start_count = r_start_cnt;
    assign o_tally.coll_count  = r_coll_cnt;
    assign o_tally.reached     = r_reached;

    `GFR_ASSERT_NOW(a_stack_empty_load, i_clk, i_rst_n, (r_state != S_LOAD) || (r_sp == '0), "Fill stack is not empty while cells load.")
    `GFR_ASSERT_NOW(a_reach_le_total, i_clk, i_rst_n, r_reached <= r_coll_cnt, "More collectibles reached than loaded.")
    `GFR_ASSERT_NOW(a_exit_seen_loaded, i_clk, i_rst_n, !r_exit_seen || (r_exit_cnt != '0), "Exit reached with no exit loaded.")
    `GFR_ASSERT_NEXT(a_done_clears, i_clk, i_rst_n, o_tally.done, (r_state == S_LOAD) && (r_load_pos == '0), "Map state not cleared after a result.")

endmodule

`default_nettype wire

>>> sv/grid_flood_fill_reachability.sv
// Top level of the grid flood-fill reachability checker: result register and verdict.
// Depends on gfr_pkg, gfr_cfg and gfr_engine.
//
// Cells are taken one per cycle in raster order while a map loads; the input is not ready
// while a map is filled or its result waits for room, nor in the cycle after each register
// write while the map shape is recomputed. After the item that marks the last cell, the block
// finds the start column one index bit at a time with the shared subtract unit, then pops each
// reachable cell and takes each neighbour through its candidate, bounds check, cell memory
// read and mark.
// No clearing pass is needed: a cell's visited mark is stored with its kind and cleared as the
// cell loads. The result waits in an output register, so the next map may load meanwhile.
`default_nettype none

module grid_flood_fill_reachability #(
    parameter int MAX_WIDTH  = gfr_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gfr_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [gfr_pkg::APB_AW-1:0] paddr,
    input  wire logic [gfr_pkg::APB_DW-1:0] pwdata,
    output logic      [gfr_pkg::APB_DW-1:0] prdata,
    output logic                            pready,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire gfr_pkg::t_in_item          i_in_data,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output gfr_pkg::t_out_item              o_out_data
);

    localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

    gfr_pkg::t_dims     dims;
    logic [CNT_W-1:0]   cap;
    gfr_pkg::t_tally    tally;
    logic               res_room;
    logic [2:0]         fail_code;
    logic               r_out_valid;
    gfr_pkg::t_out_item r_out_data;

    gfr_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CNT_W      (CNT_W)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_dims  (dims),
        .o_cap   (cap)
    );

    gfr_engine #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_dims     (dims),
        .i_cap      (cap),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_res_room (res_room),
        .o_tally    (tally)
    );

    assign res_room = !r_out_valid || i_out_ready;

    always_comb begin
        if (tally.exit_count == '0) begin
            fail_code = gfr_pkg::FAIL_NO_EXIT;
        end else if (tally.coll_count == '0) begin
            fail_code = gfr_pkg::FAIL_NO_COLL;
        end else if (tally.start_count == '0) begin
            fail_code = gfr_pkg::FAIL_NO_START;
        end else if (!tally.exit_seen) begin
            fail_code = gfr_pkg::FAIL_EXIT_UNREACH;
        end else if (tally.reached != tally.coll_count) begin
            fail_code = gfr_pkg::FAIL_COLL_UNREACH;
        end else if (tally.start_count > 13'd1) begin
            fail_code = gfr_pkg::FAIL_MANY_STARTS;
        end else if (tally.exit_count > 13'd1) begin
            fail_code = gfr_pkg::FAIL_MANY_EXITS;
        end else begin
            fail_code = gfr_pkg::FAIL_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (tally.done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tally.done) begin
            r_out_data.map_valid              <= (fail_code == gfr_pkg::FAIL_OK);
            r_out_data.exit_reachable         <= tally.exit_seen;
            r_out_data.reachable_collectibles <= tally.reached;
            r_out_data.total_collectibles     <= tally.coll_count;
            r_out_data.fail_code              <= fail_code;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

>>> verif/gfr_verdict_checker.sv
`timescale 1ns / 100ps
// Checker for the grid flood-fill block: it watches the register port and both item channels,
// works out each map's verdict with its own flood fill and compares it with the block's result.
// Depends on gfr_pkg for the item types, the kind codes and the fail codes.

module gfr_verdict_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [gfr_pkg::APB_AW-1:0] paddr,
    input  logic [gfr_pkg::APB_DW-1:0] pwdata,
    input  logic                       pready,
    input  logic                       i_in_valid,
    input  logic                       o_in_ready,
    input  gfr_pkg::t_in_item          i_in_data,
    input  logic                       o_out_valid,
    input  logic                       i_out_ready,
    input  gfr_pkg::t_out_item         o_out_data,
    output int                         o_failures,
    output int                         o_pending,
    output int                         o_checked
);

    localparam int MAX_W    = gfr_pkg::DEF_MAX_WIDTH;
    localparam int MAX_H    = gfr_pkg::DEF_MAX_HEIGHT;
    localparam int CELL_CAP = MAX_W * MAX_H;
    localparam int CW       = gfr_pkg::CFG_W;
    localparam int SAT_W    = gfr_pkg::CNT_SAT_W;
    localparam logic [gfr_pkg::APB_AW-1:0] ADDR_GRID_WIDTH  = {gfr_pkg::REG_GRID_WIDTH, 2'b00};
    localparam logic [gfr_pkg::APB_AW-1:0] ADDR_GRID_HEIGHT = {gfr_pkg::REG_GRID_HEIGHT, 2'b00};

    logic [CW-1:0]        width_reg;
    logic [CW-1:0]        height_reg;
    logic [2:0]           cell_kinds [CELL_CAP];
    bit                   reached_mark [CELL_CAP];
    int unsigned          flood_pile [$];
    int unsigned          load_pos;
    int unsigned          start_pos;
    logic [SAT_W-1:0]     exits_loaded;
    logic [SAT_W-1:0]     starts_loaded;
    logic [SAT_W-1:0]     colls_loaded;
    logic [SAT_W-1:0]     colls_reached;
    bit                   exit_reached;
    gfr_pkg::t_out_item   verdict_q [$];
    int                   failures = 0;
    int                   checked = 0;

    function automatic logic [SAT_W-1:0] count_up(input logic [SAT_W-1:0] v);
        return v + SAT_W'(v < gfr_pkg::COUNT_MAX);
    endfunction

    function automatic int unsigned shape_dim(input logic [CW-1:0] v, input int unsigned top);
        if (v == 0) return 1;
        return (v > top) ? top : v;
    endfunction

    function automatic void clear_map();
        foreach (reached_mark[i]) reached_mark[i] = 1'b0;
        flood_pile.delete();
        load_pos      = 0;
        start_pos     = 0;
        exits_loaded  = '0;
        starts_loaded = '0;
        colls_loaded  = '0;
        colls_reached = '0;
        exit_reached  = 1'b0;
    endfunction

    // Cells beyond the loaded part of the map behave as walls.
    function automatic void visit(input int unsigned idx);
        if (idx >= load_pos || idx >= CELL_CAP) return;
        if (cell_kinds[idx] == gfr_pkg::KIND_WALL || reached_mark[idx]) return;
        reached_mark[idx] = 1'b1;
        if (cell_kinds[idx] == gfr_pkg::KIND_EXIT) exit_reached = 1'b1;
        if (cell_kinds[idx] == gfr_pkg::KIND_COLL) colls_reached = count_up(colls_reached);
        flood_pile.push_back(idx);
    endfunction

    task automatic flood(input int unsigned w, input int unsigned h);
        int unsigned idx;
        int unsigned x;
        int unsigned y;
        if (starts_loaded == 0) return;
        visit(start_pos);
        while (flood_pile.size() > 0) begin
            idx = flood_pile.pop_back();
            x = idx % w;
            y = idx / w;
            if (x > 0) visit(idx - 1);
            if (x + 1 < w) visit(idx + 1);
            if (y > 0) visit(idx - w);
            if (y + 1 < h) visit(idx + w);
        end
    endtask

    task automatic take_cell(input gfr_pkg::t_in_item item);
        int unsigned        w;
        int unsigned        h;
        gfr_pkg::t_out_item verdict;
        w = shape_dim(width_reg, MAX_W);
        h = shape_dim(height_reg, MAX_H);
        if (load_pos < w * h) begin
            cell_kinds[load_pos] = item.cell_kind;
            case (item.cell_kind)
                gfr_pkg::KIND_EXIT: exits_loaded = count_up(exits_loaded);
                gfr_pkg::KIND_COLL: colls_loaded = count_up(colls_loaded);
                gfr_pkg::KIND_START: begin
                    starts_loaded = count_up(starts_loaded);
                    start_pos = load_pos;
                end
                default: ;
            endcase
            load_pos++;
        end
        if (item.last_cell) begin
            flood(w, h);
            if (exits_loaded == 0) verdict.fail_code = gfr_pkg::FAIL_NO_EXIT;
            else if (colls_loaded == 0) verdict.fail_code = gfr_pkg::FAIL_NO_COLL;
            else if (starts_loaded == 0) verdict.fail_code = gfr_pkg::FAIL_NO_START;
            else if (!exit_reached) verdict.fail_code = gfr_pkg::FAIL_EXIT_UNREACH;
            else if (colls_reached != colls_loaded)
                verdict.fail_code = gfr_pkg::FAIL_COLL_UNREACH;
            else if (starts_loaded > 1) verdict.fail_code = gfr_pkg::FAIL_MANY_STARTS;
            else if (exits_loaded > 1) verdict.fail_code = gfr_pkg::FAIL_MANY_EXITS;
            else verdict.fail_code = gfr_pkg::FAIL_OK;
            verdict.map_valid              = (verdict.fail_code == gfr_pkg::FAIL_OK);
            verdict.exit_reachable         = exit_reached;
            verdict.reachable_collectibles = colls_reached;
            verdict.total_collectibles     = colls_loaded;
            verdict_q.push_back(verdict);
            clear_map();
        end
    endtask

    task automatic match_result(input gfr_pkg::t_out_item got);
        gfr_pkg::t_out_item want;
        if (verdict_q.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("Result with no map pending: valid %0b, code %0d", got.map_valid,
                         got.fail_code);
        end else begin
            want = verdict_q.pop_front();
            checked++;
            if (got.map_valid !== want.map_valid ||
                    got.exit_reachable !== want.exit_reachable ||
                    got.reachable_collectibles !== want.reachable_collectibles ||
                    got.total_collectibles !== want.total_collectibles ||
                    got.fail_code !== want.fail_code) begin
                failures++;
                if (failures <= 10)
                    $display({"Verdict %0d differs (expected/got): valid %0b/%0b, exit %0b/%0b,",
                              " reached %0d/%0d, total %0d/%0d, code %0d/%0d"}, checked,
                             want.map_valid, got.map_valid,
                             want.exit_reachable, got.exit_reachable,
                             want.reachable_collectibles, got.reachable_collectibles,
                             want.total_collectibles, got.total_collectibles,
                             want.fail_code, got.fail_code);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = gfr_pkg::DIM_RESET;
            height_reg = gfr_pkg::DIM_RESET;
            clear_map();
            verdict_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == ADDR_GRID_WIDTH) width_reg = pwdata[CW-1:0];
                else if (paddr == ADDR_GRID_HEIGHT) height_reg = pwdata[CW-1:0];
            end
            if (i_in_valid && o_in_ready) take_cell(i_in_data);
            if (o_out_valid && i_out_ready) match_result(o_out_data);
        end
        o_pending  <= verdict_q.size();
        o_failures <= failures;
        o_checked  <= checked;
    end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the grid flood-fill block: clock, reset, register writes, cell items and
// result back-pressure. Depends on gfr_pkg, the block and gfr_verdict_checker for the verdict.

module tb_top;

    localparam int RANDOM_CELLS = 2000;
    localparam int QUIET_FROM   = 1700;
    localparam int LONG_HOLD    = 1500;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int AW           = gfr_pkg::APB_AW;
    localparam int DW           = gfr_pkg::APB_DW;
    localparam int CW           = gfr_pkg::CFG_W;
    localparam logic [AW-1:0] ADDR_GRID_WIDTH  = {gfr_pkg::REG_GRID_WIDTH, 2'b00};
    localparam logic [AW-1:0] ADDR_GRID_HEIGHT = {gfr_pkg::REG_GRID_HEIGHT, 2'b00};
    localparam logic [2:0] KIND_FLOOR  = gfr_pkg::KIND_FLOOR;
    localparam logic [2:0] KIND_WALL   = gfr_pkg::KIND_WALL;
    localparam logic [2:0] KIND_EXIT   = gfr_pkg::KIND_EXIT;
    localparam logic [2:0] KIND_COLL   = gfr_pkg::KIND_COLL;
    localparam logic [2:0] KIND_START  = gfr_pkg::KIND_START;
    localparam logic [2:0] KIND_SPARE5 = 3'd5;
    localparam logic [2:0] KIND_SPARE6 = 3'd6;
    localparam logic [2:0] KIND_SPARE7 = 3'd7;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [AW-1:0]      paddr;
    logic [DW-1:0]      pwdata;
    logic [DW-1:0]      prdata;
    logic               pready;
    logic               in_valid;
    logic               in_ready;
    gfr_pkg::t_in_item  in_data;
    logic               out_valid;
    logic               out_ready;
    gfr_pkg::t_out_item out_data;

    int         failures;
    int         pending;
    int         checked;
    int         cycle_count = 0;
    int         cells_sent = 0;
    int         maps_sent = 0;
    int         shapes_used = 0;
    int         tx_gap_odds = 0;
    bit         rx_stall_on = 1'b0;
    bit         quiet_tail = 1'b0;
    int         hold_len = 0;
    logic [2:0] plan [$];

    grid_flood_fill_reachability uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    gfr_verdict_checker verdict_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .o_failures (failures),
        .o_pending  (pending),
        .o_checked  (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d maps pending.", cycle_count, pending);
            $display("[grid_flood_fill_reachability] ERROR");
            $finish;
        end
    end

    initial begin
        int gap;
        out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_len != 0) begin
                gap = hold_len;
                hold_len = 0;
                out_ready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end else if (!quiet_tail && rx_stall_on && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(0, 7)) @(negedge i_clk);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic send_cell(input logic [2:0] kind, input logic last);
        gfr_pkg::t_in_item item;
        item.cell_kind = kind;
        item.last_cell = last;
        @(negedge i_clk);
        if (!quiet_tail && tx_gap_odds != 0 && $urandom_range(1, tx_gap_odds) == 1) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        cells_sent++;
    endtask

    task automatic send_plan();
        foreach (plan[i]) send_cell(plan[i], i == plan.size() - 1);
        maps_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [AW-1:0] addr, input logic [CW-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {(DW - CW)'($urandom()), value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_shape(input logic [CW-1:0] wv, input logic [CW-1:0] hv);
        drain();
        write_reg(ADDR_GRID_WIDTH, wv);
        write_reg(ADDR_GRID_HEIGHT, hv);
        shapes_used++;
    endtask

    // Most maps hold one start, an exit or two and a few collectibles among floor and walls;
    // the rest are noise. Some maps end early and some run past the grid.
    task automatic plan_map(input int unsigned cap);
        int unsigned n;
        int unsigned lim;
        int unsigned wall_pct;
        int unsigned pick;
        plan.delete();
        case ($urandom_range(0, 9))
            0: n = $urandom_range(1, cap);
            1: n = cap + $urandom_range(1, 4);
            default: n = cap;
        endcase
        lim = (n < cap) ? n : cap;
        wall_pct = $urandom_range(0, 40);
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < wall_pct) plan.push_back(KIND_WALL);
            else if (pick > 95) plan.push_back(3'($urandom_range(KIND_SPARE5, KIND_SPARE7)));
            else plan.push_back(KIND_FLOOR);
        end
        if ($urandom_range(0, 4) == 0) begin
            foreach (plan[i]) plan[i] = 3'($urandom_range(KIND_FLOOR, KIND_SPARE7));
        end else begin
            repeat ($urandom_range(1, 3)) plan[$urandom_range(0, lim - 1)] = KIND_COLL;
            repeat (($urandom_range(0, 5) == 0) ? 2 : 1)
                plan[$urandom_range(0, lim - 1)] = KIND_EXIT;
            repeat (($urandom_range(0, 7) == 0) ? 2 : 1)
                plan[$urandom_range(0, lim - 1)] = KIND_START;
        end
    endtask

    initial begin
        int unsigned   ew;
        int unsigned   eh;
        logic [CW-1:0] wv;
        logic [CW-1:0] hv;
        int            random_base;
        i_rst_n  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        in_valid = 1'b0;
        in_data  = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed maps on the reset shape, a wide single row, a zeroed shape and a 3 by 2 grid.
        plan = '{KIND_EXIT, KIND_COLL};
        send_plan();
        set_shape(7'd127, 7'd1);
        plan = '{KIND_START, KIND_WALL, KIND_EXIT, KIND_COLL};
        send_plan();
        plan = '{KIND_EXIT, KIND_START, KIND_WALL, KIND_COLL};
        send_plan();
        plan = '{KIND_START, KIND_START, KIND_EXIT, KIND_COLL};
        send_plan();
        plan = '{KIND_EXIT, KIND_START, KIND_EXIT, KIND_COLL};
        send_plan();
        set_shape(7'd0, 7'd0);
        plan = '{KIND_EXIT, KIND_SPARE7, KIND_START};
        send_plan();
        plan = '{KIND_START};
        send_plan();
        set_shape(7'd3, 7'd2);
        plan = '{KIND_START, KIND_WALL, KIND_EXIT, KIND_COLL, KIND_SPARE5, KIND_SPARE6};
        send_plan();

        // The receiver holds off while short maps keep coming, so the block backs up.
        set_shape(7'd4, 7'd1);
        ew = 4;
        eh = 1;
        hold_len = LONG_HOLD;
        repeat (8) begin
            plan_map(4);
            send_plan();
        end
        drain();

        random_base = cells_sent;
        while (cells_sent - random_base < RANDOM_CELLS) begin
            quiet_tail = (cells_sent - random_base) >= QUIET_FROM;
            if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 9))
                    0: begin
                        ew = 64;
                        eh = $urandom_range(1, 3);
                    end
                    1: begin
                        ew = $urandom_range(1, 3);
                        eh = 64;
                    end
                    2: begin
                        ew = $urandom_range(1, 16);
                        eh = $urandom_range(1, 16);
                    end
                    default: begin
                        ew = $urandom_range(1, 8);
                        eh = $urandom_range(1, 8);
                    end
                endcase
                wv = CW'(ew);
                hv = CW'(eh);
                if (ew == 64 && $urandom_range(0, 1) == 1) wv = CW'($urandom_range(65, 127));
                if (eh == 64 && $urandom_range(0, 1) == 1) hv = CW'($urandom_range(65, 127));
                if (ew == 1 && $urandom_range(0, 2) == 0) wv = '0;
                if (eh == 1 && $urandom_range(0, 2) == 0) hv = '0;
                set_shape(wv, hv);
            end
            case ($urandom_range(0, 2))
                0: tx_gap_odds = 0;
                1: tx_gap_odds = 2;
                default: tx_gap_odds = 8;
            endcase
            rx_stall_on = ($urandom_range(0, 2) != 0);
            plan_map(ew * eh);
            send_plan();
        end

        drain();
        repeat (64) @(posedge i_clk);
        $display("Sent %0d cells in %0d maps over %0d grid shapes; %0d verdicts compared.",
                 cells_sent, maps_sent, shapes_used, checked);
        if (failures == 0 && pending == 0) begin
            $display("[grid_flood_fill_reachability] OK");
        end else begin
            $display("[grid_flood_fill_reachability] ERROR");
        end
        $finish;
    end

endmodule
